// ===== rtl/dqc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dqc_pkg
// Types and constants used by the double-ended stack.
// ----------------------------------------------------------------------------
package dqc_pkg;

  localparam int DEPTH  = 512;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = 10;
  localparam int DATA_W = 32;

  localparam logic [2:0] MODE_PUSH_TOP = 3'd0;
  localparam logic [2:0] MODE_PUSH_BOT = 3'd1;
  localparam logic [2:0] MODE_POP_TOP  = 3'd2;
  localparam logic [2:0] MODE_POP_BOT  = 3'd3;
  localparam logic [2:0] MODE_CHECK    = 3'd4;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_EMPTY = 2'd1;
  localparam logic [1:0] STAT_FULL  = 2'd2;

  localparam logic [1:0] DIR_RISING  = 2'd1;
  localparam logic [1:0] DIR_FALLING = 2'd2;

  localparam logic [ADDR_W-1:0] LAST_SLOT = ADDR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0]  FULL_CNT  = CNT_W'(DEPTH);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_POP,
    ST_CHECK
  } state_t;

  typedef struct packed {
    logic [2:0]               mode;
    logic signed [DATA_W-1:0] value;
    logic [1:0]               direction;
  } req_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] popped_value;
    logic [1:0]               status;
    logic                     is_ordered;
    logic [CNT_W-1:0]         occupancy;
  } rsp_t;

  function automatic logic [ADDR_W-1:0] wrap_inc(input logic [ADDR_W-1:0] i);
    return (i == LAST_SLOT) ? '0 : i + 1'b1;
  endfunction

  function automatic logic [ADDR_W-1:0] wrap_dec(input logic [ADDR_W-1:0] i);
    return (i == '0) ? LAST_SLOT : i - 1'b1;
  endfunction

endpackage

// ===== rtl/dqc_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dqc_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module dqc_ram #(
  parameter int DEPTH = 512,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/double_ended_stack_with_order_check.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_ended_stack_with_order_check
// Bounded deque of signed 32-bit values in a ring-buffer RAM, with order check.
// ----------------------------------------------------------------------------
// pushes and failed operations: result in the cycle after start, busy stays low
// pops: result passes the registered RAM read, then the result register
// order check over n elements: one RAM read per element
// results cannot be stalled: done is high for exactly one cycle per request
// synchronous reset empties the store; slot contents are left as they were
module double_ended_stack_with_order_check (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  dqc_pkg::req_t req,
  output logic          done,
  output dqc_pkg::rsp_t rsp
);

  import dqc_pkg::*;

  state_t state, state_next;

  logic [ADDR_W-1:0] top_index;
  logic [ADDR_W-1:0] bottom_index;
  logic [CNT_W-1:0]  count;

  logic [ADDR_W-1:0] pos;
  logic [CNT_W-1:0]  issue_left;
  logic              rd_pend;
  logic              have_prev;
  logic [DATA_W-1:0] prev;
  logic              ok;
  logic [1:0]        chk_dir;

  logic              accept;
  logic              is_full;
  logic              is_empty;
  logic              walk;
  logic              check_done;

  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic [DATA_W-1:0] rd_data;

  assign accept     = start && !busy;
  assign is_full    = (count == FULL_CNT);
  assign is_empty   = (count == '0);
  assign walk       = ((req.direction == DIR_RISING) || (req.direction == DIR_FALLING))
                      && (count > CNT_W'(1));
  assign check_done = (issue_left == '0) && !rd_pend;

  dqc_ram #(
    .DEPTH (DEPTH),
    .WIDTH (DATA_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (req.value),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (((req.mode == MODE_POP_TOP) || (req.mode == MODE_POP_BOT)) && !is_empty) begin
            state_next = ST_POP;
          end else if ((req.mode == MODE_CHECK) && walk) begin
            state_next = ST_CHECK;
          end
        end
      end
      ST_POP:   state_next = ST_IDLE;
      ST_CHECK: begin
        if (check_done) begin
          state_next = ST_IDLE;
        end
      end
      default:  state_next = ST_IDLE;
    endcase
  end

  // memory controls and handshake
  always_comb begin
    busy    = 1'b1;
    wr_en   = 1'b0;
    wr_addr = top_index;
    rd_en   = 1'b0;
    rd_addr = wrap_dec(top_index);
    case (state)
      ST_IDLE: begin
        busy = 1'b0;
        if (accept) begin
          case (req.mode)
            MODE_PUSH_TOP: begin
              wr_en   = !is_full;
              wr_addr = top_index;
            end
            MODE_PUSH_BOT: begin
              wr_en   = !is_full;
              wr_addr = wrap_dec(bottom_index);
            end
            MODE_POP_TOP: begin
              rd_en   = !is_empty;
              rd_addr = wrap_dec(top_index);
            end
            MODE_POP_BOT: begin
              rd_en   = !is_empty;
              rd_addr = bottom_index;
            end
            MODE_CHECK: begin
              rd_en   = walk;
              rd_addr = wrap_dec(top_index);
            end
            default: ;
          endcase
        end
      end
      ST_CHECK: begin
        rd_en   = (issue_left != '0);
        rd_addr = wrap_dec(pos);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // deque pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      top_index    <= '0;
      bottom_index <= '0;
      count        <= '0;
    end else if (accept) begin
      case (req.mode)
        MODE_PUSH_TOP: begin
          if (!is_full) begin
            top_index <= wrap_inc(top_index);
            count     <= count + 1'b1;
          end
        end
        MODE_PUSH_BOT: begin
          if (!is_full) begin
            bottom_index <= wrap_dec(bottom_index);
            count        <= count + 1'b1;
          end
        end
        MODE_POP_TOP: begin
          if (!is_empty) begin
            top_index <= wrap_dec(top_index);
            count     <= count - 1'b1;
          end
        end
        MODE_POP_BOT: begin
          if (!is_empty) begin
            bottom_index <= wrap_inc(bottom_index);
            count        <= count - 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // order walk, top toward bottom, one slot read per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      issue_left <= '0;
      rd_pend    <= 1'b0;
      have_prev  <= 1'b0;
      ok         <= 1'b1;
    end else if (state == ST_IDLE) begin
      if (accept && (req.mode == MODE_CHECK) && walk) begin
        pos        <= wrap_dec(top_index);
        issue_left <= count - 1'b1;
        rd_pend    <= 1'b1;
        have_prev  <= 1'b0;
        ok         <= 1'b1;
        chk_dir    <= req.direction;
      end
    end else if (state == ST_CHECK) begin
      if (issue_left != '0) begin
        pos        <= wrap_dec(pos);
        issue_left <= issue_left - 1'b1;
      end
      rd_pend <= (issue_left != '0);
      if (rd_pend) begin
        prev      <= rd_data;
        have_prev <= 1'b1;
        // prev is the upper element, rd_data the one below it
        if (have_prev) begin
          if ((chk_dir == DIR_RISING) && ($signed(prev) > $signed(rd_data))) begin
            ok <= 1'b0;
          end
          if ((chk_dir == DIR_FALLING) && ($signed(rd_data) > $signed(prev))) begin
            ok <= 1'b0;
          end
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (accept) begin
            rsp.popped_value <= '0;
            rsp.status       <= STAT_OK;
            rsp.is_ordered   <= 1'b0;
            rsp.occupancy    <= count;
            done             <= 1'b1;
            case (req.mode)
              MODE_PUSH_TOP, MODE_PUSH_BOT: begin
                if (is_full) begin
                  rsp.status <= STAT_FULL;
                end else begin
                  rsp.occupancy <= count + 1'b1;
                end
              end
              MODE_POP_TOP, MODE_POP_BOT: begin
                if (is_empty) begin
                  rsp.status <= STAT_EMPTY;
                end else begin
                  rsp.occupancy <= count - 1'b1;
                  done          <= 1'b0;
                end
              end
              MODE_CHECK: begin
                rsp.is_ordered <= 1'b1;
                done           <= !walk;
              end
              default: ;
            endcase
          end
        end
        ST_POP: begin
          rsp.popped_value <= $signed(rd_data);
          done             <= 1'b1;
        end
        ST_CHECK: begin
          if (check_done) begin
            rsp.is_ordered <= ok;
            done           <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

endmodule
